### hw/rtl/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants of the barometer trim compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

  // Quotient bits resolved per divider stage, and the stage count
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = 64 / DIV_BITS;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_TRIM_T  = 2'd0;
  localparam logic [1:0] CFG_TRIM_PA = 2'd1;
  localparam logic [1:0] CFG_TRIM_PB = 2'd2;
  localparam logic [1:0] CFG_TRIM_PC = 2'd3;

  // Offset taken off the fine temperature before the pressure polynomial
  localparam logic [33:0] FINE_OFS = 34'd128000;
  // Bias added ahead of the P1 scaling (two to the 47th)
  localparam logic [63:0] P1_BIAS  = 64'h0000_8000_0000_0000;
  // Full scale of the raw pressure reading
  localparam logic [20:0] P_FULL   = 21'd1048576;
  // Scale of the pressure numerator
  localparam logic [63:0] P_SCALE  = 64'd3125;

  // Factory trim words
  typedef struct packed {
    logic [47:0] t;
    logic [63:0] pa;
    logic [63:0] pb;
    logic [15:0] pc;
  } btpc_trim_t;

  // Item leaving the temperature path
  typedef struct packed {
    logic [31:0]        temp;
    logic signed [33:0] x;
    logic [19:0]        adc_p;
  } btpc_tmp_t;

  // Item travelling through the divider
  typedef struct packed {
    logic [31:0] temp;
    logic        bad;
    logic        neg;
    logic [63:0] nq;
    logic [31:0] rem;
    logic [31:0] dvs;
  } btpc_div_t;

endpackage

### hw/rtl/btpc_temp.sv
// ----------------------------------------------------------------------------
// btpc_temp
// Three-stage temperature path: fine temperature, centi-degree result and
// the offset fine term for the pressure path.
// ----------------------------------------------------------------------------
module btpc_temp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [19:0]           raw_temperature_i,
  input  logic [19:0]           raw_pressure_i,
  input  btpc_pkg::btpc_trim_t  trim_i,
  output logic                  valid_o,
  output btpc_pkg::btpc_tmp_t   data_o
);
  import btpc_pkg::*;

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic signed [17:0] d1, d2;
  logic signed [33:0] pr1;
  logic signed [35:0] pr2;
  logic signed [31:0] a1_d, a1_q, sq_d, sq_q;
  logic [19:0]        ap1_q, ap2_q;
  logic               v1_q, v2_q, v3_q;
  logic signed [47:0] pr3;
  logic signed [31:0] a2;
  logic [31:0]        fine_d, fine_q;
  logic [31:0]        t5;
  btpc_tmp_t          out_d, out_q;

  assign t1 = trim_i.t[15:0];
  assign t2 = $signed(trim_i.t[31:16]);
  assign t3 = $signed(trim_i.t[47:32]);

  // Stage 1: differences and the two first products
  assign d1   = $signed({1'b0, raw_temperature_i[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2   = $signed({2'b00, raw_temperature_i[19:4]}) - $signed({2'b00, t1});
  assign pr1  = d1 * t2;
  assign pr2  = d2 * d2;
  assign a1_d = $signed(pr1[31:0]) >>> 11;
  assign sq_d = $signed(pr2[31:0]) >>> 12;

  // Stage 2: T3 term and fine temperature
  assign pr3    = sq_q * t3;
  assign a2     = $signed(pr3[31:0]) >>> 14;
  assign fine_d = a1_q + a2;

  // Stage 3: centi-degrees and offset fine term
  assign t5          = {fine_q[29:0], 2'b00} + fine_q + 32'd128;
  assign out_d.temp  = $signed(t5) >>> 8;
  assign out_d.x     = $signed({{2{fine_q[31]}}, fine_q} - FINE_OFS);
  assign out_d.adc_p = ap2_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= a1_d;
      sq_q   <= sq_d;
      ap1_q  <= raw_pressure_i;
      fine_q <= fine_d;
      ap2_q  <= ap1_q;
      out_q  <= out_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = out_q;

endmodule

### hw/rtl/btpc_coef.sv
// ----------------------------------------------------------------------------
// btpc_coef
// Six-stage pressure front end: polynomial terms, divisor, numerator and
// their sign and magnitude split for the divider.
// ----------------------------------------------------------------------------
module btpc_coef (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  btpc_pkg::btpc_tmp_t   data_i,
  input  btpc_pkg::btpc_trim_t  trim_i,
  output logic                  valid_o,
  output btpc_pkg::btpc_div_t   data_o
);
  import btpc_pkg::*;

  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6;
  logic [5:0]         v_q;
  logic [31:0]        tmp1_q, tmp2_q, tmp3_q, tmp4_q, tmp5_q;
  logic [19:0]        ap1_q, ap2_q, ap3_q;
  // stage 1
  logic signed [67:0] xxw;
  logic signed [49:0] xp5w, xp2w;
  logic [63:0]        xx_q;
  logic signed [49:0] xp5_q, xp2_q;
  // stage 2
  logic signed [79:0] y6w, xp3w;
  logic [63:0]        y6_q, xp3_q, xp5s_q, xp2s_q;
  // stage 3
  logic [63:0]        p4s, y_d, y_q, xs_d, xs_q;
  // stage 4
  logic [63:0]        base;
  logic signed [80:0] mw;
  logic [20:0]        dp;
  logic [63:0]        m_q, pn_d, pn_q;
  // stage 5
  logic [63:0]        num_d, num_q;
  logic [30:0]        xd_q;
  logic               bad_q;
  // stage 6
  logic [31:0]        xd32;
  btpc_div_t          out_d, out_q;

  assign p1 = trim_i.pa[15:0];
  assign p2 = $signed(trim_i.pa[31:16]);
  assign p3 = $signed(trim_i.pa[47:32]);
  assign p4 = $signed(trim_i.pa[63:48]);
  assign p5 = $signed(trim_i.pb[15:0]);
  assign p6 = $signed(trim_i.pb[31:16]);

  // Stage 1: square and linear products
  assign xxw  = data_i.x * data_i.x;
  assign xp5w = data_i.x * p5;
  assign xp2w = data_i.x * p2;

  // Stage 2: square times P6 and P3
  assign y6w  = $signed(xx_q) * p6;
  assign xp3w = $signed(xx_q) * p3;

  // Stage 3: sums of the two polynomials
  assign p4s  = 64'(p4) << 35;
  assign y_d  = y6_q + xp5s_q + p4s;
  assign xs_d = 64'($signed(xp3_q) >>> 8) + xp2s_q;

  // Stage 4: P1 scaling and numerator before scale
  assign base = xs_q + P1_BIAS;
  assign mw   = $signed(base) * $signed({1'b0, p1});
  assign dp   = P_FULL - {1'b0, ap3_q};
  assign pn_d = ({43'd0, dp} << 31) - y_q;

  // Stage 5: numerator scale
  assign num_d = pn_q * P_SCALE;

  // Stage 6: sign and magnitude for the divider
  assign xd32       = 32'($signed(xd_q));
  assign out_d.temp = tmp5_q;
  assign out_d.bad  = bad_q;
  assign out_d.neg  = num_q[63] ^ xd_q[30];
  assign out_d.nq   = num_q[63] ? (64'd0 - num_q) : num_q;
  assign out_d.rem  = 32'd0;
  assign out_d.dvs  = xd_q[30] ? (32'd0 - xd32) : xd32;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tmp1_q <= data_i.temp;
      ap1_q  <= data_i.adc_p;
      xx_q   <= xxw[63:0];
      xp5_q  <= xp5w;
      xp2_q  <= xp2w;

      tmp2_q <= tmp1_q;
      ap2_q  <= ap1_q;
      y6_q   <= y6w[63:0];
      xp3_q  <= xp3w[63:0];
      xp5s_q <= 64'(xp5_q) << 17;
      xp2s_q <= 64'(xp2_q) << 12;

      tmp3_q <= tmp2_q;
      ap3_q  <= ap2_q;
      y_q    <= y_d;
      xs_q   <= xs_d;

      tmp4_q <= tmp3_q;
      m_q    <= mw[63:0];
      pn_q   <= pn_d;

      tmp5_q <= tmp4_q;
      num_q  <= num_d;
      xd_q   <= m_q[63:33];
      bad_q  <= (m_q[63:33] == 31'd0);

      out_q  <= out_d;
    end
  end

  assign valid_o = v_q[5];
  assign data_o  = out_q;

endmodule

### hw/rtl/btpc_div_stage.sv
// ----------------------------------------------------------------------------
// btpc_div_stage
// One registered stage of the restoring divider: resolves DIV_BITS quotient
// bits of the unsigned magnitude division.
// ----------------------------------------------------------------------------
module btpc_div_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  btpc_pkg::btpc_div_t  data_i,
  output logic                 valid_o,
  output btpc_pkg::btpc_div_t  data_o
);
  import btpc_pkg::*;

  btpc_div_t st;
  btpc_div_t data_q;
  logic      valid_q;

  // Shift in dividend bits, subtract divisor where it fits
  always_comb begin
    logic [32:0] r;
    st = data_i;
    r  = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      r     = {st.rem, st.nq[63]};
      st.nq = {st.nq[62:0], 1'b0};
      if (r >= {1'b0, st.dvs}) begin
        r        = r - {1'b0, st.dvs};
        st.nq[0] = 1'b1;
      end
      st.rem = r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= st;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

`ifndef SYNTHESIS
  // Partial remainder stays below the divisor whenever the divisor is nonzero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (data_q.dvs != 32'd0) |-> (data_q.rem < data_q.dvs))
    else $error("divider remainder not below divisor");

  // Sign and flag ride along unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i |=> valid_o && (data_o.neg == $past(data_i.neg))
      && (data_o.bad == $past(data_i.bad)))
    else $error("divider side data lost");
`endif

endmodule

### hw/rtl/btpc_post.sv
// ----------------------------------------------------------------------------
// btpc_post
// Six-stage pressure back end: quotient sign, P9/P8 corrections, P7 offset
// and the output register.
// ----------------------------------------------------------------------------
module btpc_post (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  btpc_pkg::btpc_div_t   data_i,
  input  btpc_pkg::btpc_trim_t  trim_i,
  output logic                  valid_o,
  output logic [31:0]           temp_o,
  output logic [31:0]           pres_o,
  output logic                  bad_o
);
  import btpc_pkg::*;

  logic signed [15:0] p7, p8, p9;
  logic [5:0]         v_q;
  logic [31:0]        tmp1_q, tmp2_q, tmp3_q, tmp4_q, tmp5_q, tmp6_q;
  logic               bad1_q, bad2_q, bad3_q, bad4_q, bad5_q, bad6_q;
  logic [63:0]        q1_q, q2_q, q3_q, q4_q;
  logic [63:0]        h;
  logic signed [79:0] phw, c2w;
  logic [63:0]        ph_q, h_q, c2p_q;
  logic [63:0]        lo;
  logic [31:0]        m1, m2;
  logic [63:0]        lo_q, c2_q, c2b_q;
  logic [31:0]        mx_q;
  logic [63:0]        hh_q;
  logic [63:0]        s_d, s_q;
  logic [63:0]        r64;
  logic [31:0]        pres_q;

  assign p7 = $signed(trim_i.pb[47:32]);
  assign p8 = $signed(trim_i.pb[63:48]);
  assign p9 = $signed(trim_i.pc);

  // Stage 2: P9 and P8 products
  assign h   = 64'($signed(q1_q) >>> 13);
  assign phw = $signed(h) * p9;
  assign c2w = $signed(q1_q) * p8;

  // Stage 3: partial products of the wrapped 64 by 64 product
  assign lo = ph_q[31:0] * h_q[31:0];
  assign m1 = ph_q[31:0] * h_q[63:32];
  assign m2 = ph_q[63:32] * h_q[31:0];

  // Stage 5: sum of corrections
  assign s_d = q4_q + 64'($signed(hh_q) >>> 25) + c2b_q;

  // Stage 6: scale down and add the P7 offset
  assign r64 = 64'($signed(s_q) >>> 8) + (64'(p7) << 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: quotient sign
      q1_q   <= data_i.neg ? (64'd0 - data_i.nq) : data_i.nq;
      tmp1_q <= data_i.temp;
      bad1_q <= data_i.bad;
      // stage 2
      ph_q   <= phw[63:0];
      h_q    <= h;
      c2p_q  <= c2w[63:0];
      q2_q   <= q1_q;
      tmp2_q <= tmp1_q;
      bad2_q <= bad1_q;
      // stage 3
      lo_q   <= lo;
      mx_q   <= m1 + m2;
      c2_q   <= 64'($signed(c2p_q) >>> 19);
      q3_q   <= q2_q;
      tmp3_q <= tmp2_q;
      bad3_q <= bad2_q;
      // stage 4
      hh_q   <= lo_q + {mx_q, 32'd0};
      c2b_q  <= c2_q;
      q4_q   <= q3_q;
      tmp4_q <= tmp3_q;
      bad4_q <= bad3_q;
      // stage 5
      s_q    <= s_d;
      tmp5_q <= tmp4_q;
      bad5_q <= bad4_q;
      // stage 6: output register
      pres_q <= bad5_q ? 32'd0 : r64[31:0];
      tmp6_q <= tmp5_q;
      bad6_q <= bad5_q;
    end
  end

  assign valid_o = v_q[5];
  assign temp_o  = tmp6_q;
  assign pres_o  = pres_q;
  assign bad_o   = bad6_q;

endmodule

### hw/rtl/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Barometer trim compensation: temperature in 0.01 degC and pressure in Pa
// (Q24.8) from raw converter readings and factory trim words.
//
//   channel | direction | handshake                | payload
//   in      | sink      | in_valid_i / in_stall_o  | raw_temperature_i, raw_pressure_i
//   out     | source    | out_valid_o / out_stall_i| temperature_centi_o, pressure_q24_8_o,
//           |           |                          | pressure_invalid_o
//   cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item enters per cycle while the output is not stalled; the stages are 3 temperature,
// 6 pressure front end, 16 divider stages of 4 quotient bits and 6 back end.
// A stall on the output freezes the whole pipeline; in_stall_o follows it.
// Reset clears valid bits and trim words; no clearing pass.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] temperature_centi_o,
  output logic [31:0] pressure_q24_8_o,
  output logic        pressure_invalid_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import btpc_pkg::*;

  btpc_trim_t trim_q;
  logic       en;
  logic       tmp_v;
  btpc_tmp_t  tmp_d;
  logic       div_v [DIV_STAGES+1];
  btpc_div_t  div_d [DIV_STAGES+1];
  logic [31:0] temp_w;

  // Whole pipeline advances unless a finished item is held
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // Trim word registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TRIM_T:  trim_q.t  <= cfg_data_i[47:0];
        CFG_TRIM_PA: trim_q.pa <= cfg_data_i;
        CFG_TRIM_PB: trim_q.pb <= cfg_data_i;
        CFG_TRIM_PC: trim_q.pc <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  btpc_temp u_temp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (in_valid_i),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .trim_i            (trim_q),
    .valid_o           (tmp_v),
    .data_o            (tmp_d)
  );

  btpc_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tmp_v),
    .data_i  (tmp_d),
    .trim_i  (trim_q),
    .valid_o (div_v[0]),
    .data_o  (div_d[0])
  );

  // Divider chain
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    btpc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_v[g]),
      .data_i  (div_d[g]),
      .valid_o (div_v[g+1]),
      .data_o  (div_d[g+1])
    );
  end

  btpc_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_v[DIV_STAGES]),
    .data_i  (div_d[DIV_STAGES]),
    .trim_i  (trim_q),
    .valid_o (out_valid_o),
    .temp_o  (temp_w),
    .pres_o  (pressure_q24_8_o),
    .bad_o   (pressure_invalid_o)
  );

  assign temperature_centi_o = $signed(temp_w);

`ifndef SYNTHESIS
  // Zero divisor forces pressure to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pressure_invalid_o |-> (pressure_q24_8_o == 32'd0))
    else $error("invalid pressure not forced to zero");

  // A stalled output item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(temperature_centi_o)
      && $stable(pressure_q24_8_o) && $stable(pressure_invalid_o))
    else $error("stalled output item changed");

  // Input stalls exactly when a finished item is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall out of step with output");
`endif

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the barometer trim compensation pipeline. Each
// accepted sample pair is run through a local model of the temperature and
// pressure arithmetic. Each output item is checked against the oldest
// prediction. Both channels idle at random, and trim words change between
// phases.
// ----------------------------------------------------------------------------
module testbench;
  import btpc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [19:0] raw_temperature_i = '0;
  logic [19:0] raw_pressure_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] temperature_centi_o;
  logic [31:0] pressure_q24_8_o;
  logic        pressure_invalid_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] pres;
    logic        bad;
  } reading_t;

  // Local copy of the trim words
  logic [47:0] trim_t;
  logic [63:0] trim_pa;
  logic [63:0] trim_pb;
  logic [15:0] trim_pc;

  reading_t pending_readings[$];
  int       errors = 0;
  bit       no_idle = 1'b0;

  baro_temp_pressure_compensation u_dut (.*);

  always #4 clk_i = ~clk_i;

  // Run limit
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [31:0] asr32(logic [31:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] sext16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Signed divide truncated toward zero; MIN / -1 wraps
  function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] b);
    logic [63:0] ma, mb, q;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q  = ma / mb;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  // Compensated temperature and pressure for one sample pair
  function automatic reading_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
    logic [31:0] adc_t, t1, t2, t3, d1, a1, d2, sq, a2, fine, tmp;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] x, y, w, num, p, h, c1, c2;
    reading_t r;
    adc_t = {12'd0, raw_t};
    t1 = {16'd0, trim_t[15:0]};
    t2 = {{16{trim_t[31]}}, trim_t[31:16]};
    t3 = {{16{trim_t[47]}}, trim_t[47:32]};
    d1 = (adc_t >> 3) - (t1 << 1);
    tmp = d1 * t2;
    a1 = asr32(tmp, 11);
    d2 = (adc_t >> 4) - t1;
    sq = d2 * d2;
    tmp = asr32(sq, 12) * t3;
    a2 = asr32(tmp, 14);
    fine = a1 + a2;
    tmp = fine * 32'd5 + 32'd128;
    r.temp = asr32(tmp, 8);

    p1 = {48'd0, trim_pa[15:0]};
    p2 = sext16(trim_pa[31:16]);
    p3 = sext16(trim_pa[47:32]);
    p4 = sext16(trim_pa[63:48]);
    p5 = sext16(trim_pb[15:0]);
    p6 = sext16(trim_pb[31:16]);
    p7 = sext16(trim_pb[47:32]);
    p8 = sext16(trim_pb[63:48]);
    p9 = sext16(trim_pc);

    x = {{32{fine[31]}}, fine} - 64'd128000;
    y = x * x * p6;
    y = y + ((x * p5) << 17);
    y = y + (p4 << 35);
    w = x * x * p3;
    x = asr64(w, 8) + ((x * p2) << 12);
    w = ((64'd1 << 47) + x) * p1;
    x = asr64(w, 33);

    r.pres = '0;
    r.bad  = 1'b0;
    if (x == 64'd0) begin
      r.bad = 1'b1;
    end else begin
      p   = 64'd1048576 - {44'd0, raw_p};
      num = ((p << 31) - y) * 64'd3125;
      p   = div_trunc(num, x);
      h   = asr64(p, 13);
      c1  = asr64(p9 * h * h, 25);
      c2  = asr64(p8 * p, 19);
      p   = asr64(p + c1 + c2, 8) + (p7 << 4);
      r.pres = p[31:0];
    end
    return r;
  endfunction

  // Check each output item against the oldest prediction
  always @(posedge clk_i) begin
    reading_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected output item temp %0d pres %h", $time,
                 temperature_centi_o, pressure_q24_8_o);
        errors++;
      end else begin
        e = pending_readings.pop_front();
        if (temperature_centi_o !== e.temp) begin
          $display("%0t: temperature exp %0d act %0d", $time,
                   $signed(e.temp), temperature_centi_o);
          errors++;
        end
        if (pressure_q24_8_o !== e.pres) begin
          $display("%0t: pressure exp %h act %h", $time, e.pres, pressure_q24_8_o);
          errors++;
        end
        if (pressure_invalid_o !== e.bad) begin
          $display("%0t: invalid flag exp %b act %b", $time, e.bad, pressure_invalid_o);
          errors++;
        end
      end
    end
  end

  // Output side: random stall before each item
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      n = no_idle ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Send one sample pair; called and returns at a falling edge
  task automatic send_item(logic [19:0] raw_t, logic [19:0] raw_p);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_temperature_i <= raw_t;
    raw_pressure_i    <= raw_p;
    do @(posedge clk_i); while (in_stall_o);
    pending_readings.push_back(compensate(raw_t, raw_p));
    @(negedge clk_i);
  endtask

  // Let the pipeline drain before touching the trim words
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // One register write; valid stays high for back-to-back writes
  task automatic write_trim(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TRIM_T:  trim_t  = data[47:0];
      CFG_TRIM_PA: trim_pa = data;
      CFG_TRIM_PB: trim_pb = data;
      CFG_TRIM_PC: trim_pc = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_trims(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
                           logic [15:0] pc);
    wait_idle();
    write_trim(CFG_TRIM_T, {16'd0, t});
    write_trim(CFG_TRIM_PA, pa);
    write_trim(CFG_TRIM_PB, pb);
    write_trim(CFG_TRIM_PC, {48'd0, pc});
    cfg_valid_i <= 1'b0;
  endtask

  // Trim set in the range of a real part, with some spread
  task automatic set_typical_trims();
    logic [15:0] t1, t2, t3, q1, q2, q3, q4, q5, q6, q7, q8, q9;
    t1 = 16'(27504 + $signed($urandom_range(0, 4000)) - 2000);
    t2 = 16'(26435 + $signed($urandom_range(0, 2000)) - 1000);
    t3 = 16'(-1000 + $signed($urandom_range(0, 400)) - 200);
    q1 = 16'(36477 + $signed($urandom_range(0, 4000)) - 2000);
    q2 = 16'(-10685 + $signed($urandom_range(0, 1000)) - 500);
    q3 = 16'(3024 + $signed($urandom_range(0, 400)) - 200);
    q4 = 16'(2855 + $signed($urandom_range(0, 400)) - 200);
    q5 = 16'(140 + $signed($urandom_range(0, 100)) - 50);
    q6 = 16'(-7 + $signed($urandom_range(0, 10)) - 5);
    q7 = 16'(15500 + $signed($urandom_range(0, 1000)) - 500);
    q8 = 16'(-14600 + $signed($urandom_range(0, 1000)) - 500);
    q9 = 16'(6000 + $signed($urandom_range(0, 1000)) - 500);
    set_trims({t3, t2, t1}, {q4, q3, q2, q1}, {q8, q7, q6, q5}, q9);
  endtask

  // Zero trim after reset: divisor is zero, pressure flagged
  task automatic test_reset_trims();
    send_item(20'd0, 20'd0);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'd519888, 20'd415148);
  endtask

  // Field extremes under typical and extreme trim words
  task automatic test_directed();
    set_trims({16'hFC18, 16'd26435, 16'd27504}, {16'd2855, 16'd3024, 16'hD643, 16'd36477},
              {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
    send_item(20'd519888, 20'd415148);
    send_item(20'd0, 20'd0);
    send_item(20'hFFFFF, 20'd0);
    send_item(20'd0, 20'hFFFFF);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'h55555, 20'hAAAAA);
    set_trims('1, '1, '1, 16'hFFFF);
    send_item(20'd0, 20'd0);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'h80000, 20'h7FFFF);
    set_trims({16'h7FFF, 16'h8000, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
              {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
    send_item(20'd0, 20'd0);
    send_item(20'hFFFFF, 20'hFFFFF);
    send_item(20'h12345, 20'h54321);
    // P1 of zero forces the zero divisor with a live temperature
    set_trims({16'hFC18, 16'd26435, 16'd27504}, 64'h0B27_0BD0_D643_0000, '0, '0);
    send_item(20'd519888, 20'd415148);
    send_item(20'hFFFFF, 20'd1);
  endtask

  // Random phases; mostly realistic trims, some fully random words
  task automatic test_random();
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 2)
        set_trims(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom));
      else
        set_typical_trims();
      no_idle = (ph % 4 == 1);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_item(20'($urandom), 20'($urandom));
        else
          send_item(20'(400000 + $urandom_range(0, 250000)),
                    20'(250000 + $urandom_range(0, 350000)));
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    trim_t  = '0;
    trim_pa = '0;
    trim_pb = '0;
    trim_pc = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_trims();
    test_directed();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
